FILE: sv/drbf_pkg.sv
// Package for the damped resonator bank filter: shared types, register codes,
// fixed-point widths and the polynomial coefficients of the rotator.
// Depends on nothing; every other file imports it.
`default_nettype none

package drbf_pkg;

   localparam int DEF_BINS = 1024;

   // Widths of the datapath.
   localparam int ANG_W   = 24;
   localparam int POLY_W  = 34;
   localparam int ROT_W   = 26;
   localparam int STATE_W = 32;
   localparam int RES_W   = 35;

   // Configuration register indexes.
   localparam logic [1:0] REG_FIRST_DECAY  = 2'd0;
   localparam logic [1:0] REG_SECOND_DECAY = 2'd1;
   localparam logic [1:0] REG_FREQ_STEP    = 2'd2;
   localparam logic [1:0] REG_OUTPUT_GAIN  = 2'd3;

   localparam logic [15:0] FIRST_DECAY_RST  = 16'd65442;
   localparam logic [15:0] SECOND_DECAY_RST = 16'd64596;
   localparam logic [23:0] FREQ_STEP_RST    = 24'd4096;
   localparam logic [7:0]  OUTPUT_GAIN_RST  = 8'd50;

   // Sine (odd) and cosine (even) polynomial coefficients, scale 2^-24.
   localparam logic signed [POLY_W-1:0] C_SIN1  =  34'sd105414357;
   localparam logic signed [POLY_W-1:0] C_SIN3  = -34'sd693598668;
   localparam logic signed [POLY_W-1:0] C_SIN5  =  34'sd1369108894;
   localparam logic signed [POLY_W-1:0] C_SIN7  = -34'sd1286910777;
   localparam logic signed [POLY_W-1:0] C_SIN9  =  34'sd705629141;
   localparam logic signed [POLY_W-1:0] C_COS0  =  34'sd16777216;
   localparam logic signed [POLY_W-1:0] C_COS2  = -34'sd331168970;
   localparam logic signed [POLY_W-1:0] C_COS4  =  34'sd1089502240;
   localparam logic signed [POLY_W-1:0] C_COS6  = -34'sd1433727478;
   localparam logic signed [POLY_W-1:0] C_COS8  =  34'sd1010737338;
   localparam logic signed [POLY_W-1:0] C_COS10 = -34'sd443358904;

   // Control that travels alongside a bin through the pipelines.
   typedef struct packed {
      logic vld;
      logic last;
   } drbf_tag_type;

endpackage

`default_nettype wire

FILE: sv/damped_resonator_bank_filter_core.sv
// Damped resonator bank filter: one result per request.
// A new request is taken only in the idle state, after the previous result has
// been loaded; the bank memories are swept one bin per cycle for each request.
// Reset: synchronous; the registers take their defaults and a clearing pass
// zeroes both state memories before the first request is taken.
`default_nettype none

module damped_resonator_bank_filter_core
   import drbf_pkg::*;
#(
   parameter int BINS = DEF_BINS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [15:0] req_audio_in,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [23:0]      rsp_filtered_out,
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_index,
   input  wire logic [23:0]        csr_wdata
);

   localparam int BIN_W  = (BINS > 1) ? $clog2(BINS) : 1;
   localparam int SUM_W  = STATE_W + BIN_W + 1;
   localparam int PROD_W = SUM_W + 9;
   localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(BINS - 1);
   localparam logic signed [PROD_W-1:0] OUT_MAX = PROD_W'(64'sd8388607);
   localparam logic signed [PROD_W-1:0] OUT_MIN = -PROD_W'(64'sd8388608);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CLEAR = 3'd1;
   localparam logic [2:0] ST_RUN   = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_MUL   = 3'd4;
   localparam logic [2:0] ST_SAT   = 3'd5;

   logic [2:0]                state_ff, state_in;
   logic [BIN_W-1:0]          k_ff, k_in;
   logic [ANG_W-1:0]          angle_ff, angle_in;
   logic signed [15:0]        sample_ff;
   logic signed [SUM_W-1:0]   sum_ff;
   logic signed [PROD_W-1:0]  prod_ff, res_sh;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [23:0]        rsp_data_ff;
   logic [15:0]               first_decay_ff, second_decay_ff;
   logic [23:0]               freq_step_ff;
   logic [7:0]                output_gain_ff;

   drbf_tag_type              rot_in, rot_out, bank_out;
   logic [BIN_W-1:0]          rot_k;
   logic signed [ROT_W-1:0]   rot_cos, rot_sin;
   logic signed [STATE_W-1:0] two_re;
   logic                      accept, out_load;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign out_load  = (state_ff == ST_SAT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in   = state_ff;
      k_in       = k_ff;
      angle_in   = angle_ff;
      rot_in.vld  = 1'b0;
      rot_in.last = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            k_in = k_ff + 1'b1;
            if (k_ff == LAST_BIN) begin
               k_in     = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               k_in     = '0;
               angle_in = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            rot_in.vld  = 1'b1;
            rot_in.last = (k_ff == LAST_BIN);
            k_in        = k_ff + 1'b1;
            angle_in    = angle_ff + freq_step_ff;
            if (k_ff == LAST_BIN) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (bank_out.vld && bank_out.last) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_SAT;
         end
         ST_SAT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
      res_sh = prod_ff >>> 13;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         k_ff            <= '0;
         rsp_valid_ff    <= 1'b0;
         first_decay_ff  <= FIRST_DECAY_RST;
         second_decay_ff <= SECOND_DECAY_RST;
         freq_step_ff    <= FREQ_STEP_RST;
         output_gain_ff  <= OUTPUT_GAIN_RST;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               REG_FIRST_DECAY:  first_decay_ff  <= csr_wdata[15:0];
               REG_SECOND_DECAY: second_decay_ff <= csr_wdata[15:0];
               REG_FREQ_STEP:    freq_step_ff    <= csr_wdata;
               REG_OUTPUT_GAIN:  output_gain_ff  <= csr_wdata[7:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      angle_ff <= angle_in;
      if (accept) begin
         sample_ff <= req_audio_in;
         sum_ff    <= '0;
      end else if (bank_out.vld) begin
         sum_ff <= sum_ff + SUM_W'(two_re);
      end
      prod_ff <= sum_ff * $signed({1'b0, output_gain_ff});
      if (out_load) begin
         if (res_sh > OUT_MAX) begin
            rsp_data_ff <= 24'sh7FFFFF;
         end else if (res_sh < OUT_MIN) begin
            rsp_data_ff <= 24'sh800000;
         end else begin
            rsp_data_ff <= 24'(res_sh);
         end
      end
   end

   drbf_rot #(
      .BIN_W (BIN_W)
   ) u_rot (
      .clock    (clock),
      .reset    (reset),
      .tag_in   (rot_in),
      .k_in     (k_ff),
      .angle_in (angle_ff),
      .tag_out  (rot_out),
      .k_out    (rot_k),
      .cos_out  (rot_cos),
      .sin_out  (rot_sin)
   );

   drbf_bank #(
      .BINS  (BINS),
      .BIN_W (BIN_W)
   ) u_bank (
      .clock        (clock),
      .reset        (reset),
      .clr_en       (state_ff == ST_CLEAR),
      .clr_addr     (k_ff),
      .tag_in       (rot_out),
      .k_in         (rot_k),
      .cos_in       (rot_cos),
      .sin_in       (rot_sin),
      .sample       (sample_ff),
      .first_decay  (first_decay_ff),
      .second_decay (second_decay_ff),
      .tag_out      (bank_out),
      .two_re_out   (two_re)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_filtered_out = rsp_data_ff;

   // Finished bins only come back while a request is being worked on.
   a_bins_in_run: assert property (@(posedge clock) disable iff (reset)
      bank_out.vld |-> (state_ff == ST_RUN || state_ff == ST_DRAIN))
      else $error("bin result outside a request");

   // No bin enters the rotator while the memories are being cleared.
   a_no_issue_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rot_in.vld)
      else $error("bin issued during clearing pass");

   // A new result only appears from the saturation step.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_SAT)
      else $error("result raised outside saturation step");

   // Issuing the last bin of a request moves the core into the drain state.
   a_last_issue: assert property (@(posedge clock) disable iff (reset)
      (rot_in.vld && rot_in.last) |=> (state_ff == ST_DRAIN))
      else $error("last bin issued without draining");

endmodule

`default_nettype wire

FILE: sv/drbf_rot.sv
// Rotator pipeline: turns a bin angle into its cosine and sine at scale 2^-24
// in seven stages (square, four Horner steps, final step, quadrant swap).
// Depends on drbf_pkg.
`default_nettype none

module drbf_rot
   import drbf_pkg::*;
#(
   parameter int BIN_W = 10
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire drbf_tag_type            tag_in,
   input  wire logic [BIN_W-1:0]        k_in,
   input  wire logic [ANG_W-1:0]        angle_in,
   output drbf_tag_type                 tag_out,
   output logic [BIN_W-1:0]             k_out,
   output logic signed [ROT_W-1:0]      cos_out,
   output logic signed [ROT_W-1:0]      sin_out
);

   function automatic logic signed [POLY_W-1:0] horner(
      input logic signed [POLY_W-1:0] p,
      input logic signed [19:0]       x,
      input logic signed [POLY_W-1:0] c
   );
      logic signed [POLY_W+19:0] prod;
      prod = p * x;
      return POLY_W'(prod >>> 24) + c;
   endfunction

   drbf_tag_type              tag_ff [1:7];
   logic [BIN_W-1:0]          k_ff   [1:7];
   logic [1:0]                q_ff   [1:6];
   logic signed [22:0]        u_ff   [1:5];
   logic signed [19:0]        u2_ff  [1:5];
   logic signed [POLY_W-1:0]  ps_ff  [2:5];
   logic signed [POLY_W-1:0]  pc_ff  [2:5];
   logic signed [ROT_W-1:0]   sv_ff, cv_ff, cos_ff, sin_ff;

   logic [ANG_W-1:0]          b_in;
   logic signed [22:0]        u_in;
   logic signed [45:0]        uu_in;
   logic signed [56:0]        su_in;
   logic signed [POLY_W-1:0]  cv_in;

   always_comb begin
      // Centre the angle on the quadrant so the residual stays within an eighth turn.
      b_in  = angle_in + 24'h200000;
      u_in  = $signed({1'b0, b_in[21:0]}) - 23'sd2097152;
      uu_in = u_in * u_in;
      su_in = ps_ff[5] * u_ff[5];
      cv_in = horner(pc_ff[5], u2_ff[5], C_COS0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= 7; i++) begin
            tag_ff[i] <= '0;
         end
      end else begin
         tag_ff[1] <= tag_in;
         for (int i = 2; i <= 7; i++) begin
            tag_ff[i] <= tag_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff[1]  <= k_in;
      q_ff[1]  <= b_in[23:22];
      u_ff[1]  <= u_in;
      u2_ff[1] <= uu_in[43:24];
      for (int i = 2; i <= 7; i++) begin
         k_ff[i] <= k_ff[i-1];
      end
      for (int i = 2; i <= 6; i++) begin
         q_ff[i] <= q_ff[i-1];
      end
      for (int i = 2; i <= 5; i++) begin
         u_ff[i]  <= u_ff[i-1];
         u2_ff[i] <= u2_ff[i-1];
      end
      ps_ff[2] <= horner(C_SIN9, u2_ff[1], C_SIN7);
      pc_ff[2] <= horner(C_COS10, u2_ff[1], C_COS8);
      ps_ff[3] <= horner(ps_ff[2], u2_ff[2], C_SIN5);
      pc_ff[3] <= horner(pc_ff[2], u2_ff[2], C_COS6);
      ps_ff[4] <= horner(ps_ff[3], u2_ff[3], C_SIN3);
      pc_ff[4] <= horner(pc_ff[3], u2_ff[3], C_COS4);
      ps_ff[5] <= horner(ps_ff[4], u2_ff[4], C_SIN1);
      pc_ff[5] <= horner(pc_ff[4], u2_ff[4], C_COS2);
      sv_ff    <= ROT_W'(su_in >>> 24);
      cv_ff    <= ROT_W'(cv_in);
      case (q_ff[6])
         2'd0: begin
            cos_ff <= cv_ff;
            sin_ff <= sv_ff;
         end
         2'd1: begin
            cos_ff <= -sv_ff;
            sin_ff <= cv_ff;
         end
         2'd2: begin
            cos_ff <= -cv_ff;
            sin_ff <= -sv_ff;
         end
         default: begin
            cos_ff <= sv_ff;
            sin_ff <= -cv_ff;
         end
      endcase
   end

   assign tag_out = tag_ff[7];
   assign k_out   = k_ff[7];
   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

`default_nettype wire

FILE: sv/drbf_bank.sv
// Resonator bank: both state memories and the seven-stage read, rotate,
// decay, mix and write-back datapath for one bin per cycle.
// Depends on drbf_pkg.
`default_nettype none

module drbf_bank
   import drbf_pkg::*;
#(
   parameter int BINS  = DEF_BINS,
   parameter int BIN_W = 10
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    clr_en,
   input  wire logic [BIN_W-1:0]        clr_addr,
   input  wire drbf_tag_type            tag_in,
   input  wire logic [BIN_W-1:0]        k_in,
   input  wire logic signed [ROT_W-1:0] cos_in,
   input  wire logic signed [ROT_W-1:0] sin_in,
   input  wire logic signed [15:0]      sample,
   input  wire logic [15:0]             first_decay,
   input  wire logic [15:0]             second_decay,
   output drbf_tag_type                 tag_out,
   output logic signed [STATE_W-1:0]    two_re_out
);

   localparam int PROD_W = STATE_W + ROT_W;
   localparam int MUL_W  = RES_W + 17;
   localparam int MIX_W  = MUL_W + 1;

   function automatic logic signed [STATE_W-1:0] clamp32(
      input logic signed [MIX_W-1:0] v
   );
      logic signed [MIX_W-1:0] s;
      s = v >>> 16;
      if (s > MIX_W'(64'sd2147483647)) begin
         return 32'sh7FFFFFFF;
      end else if (s < -MIX_W'(64'sd2147483648)) begin
         return 32'sh80000000;
      end
      return STATE_W'(s);
   endfunction

   logic [2*STATE_W-1:0] mem_one [BINS];
   logic [2*STATE_W-1:0] mem_two [BINS];

   drbf_tag_type               tag_ff [1:7];
   logic [BIN_W-1:0]           k_ff   [1:6];
   logic signed [ROT_W-1:0]    c_ff, s_ff;
   logic [2*STATE_W-1:0]       rd1_ff, rd2_ff;
   logic signed [PROD_W-1:0]   pa_ff, pb_ff, pc_ff, pd_ff, pe_ff, pf_ff, pg_ff, ph_ff;
   logic signed [RES_W-1:0]    r1re_ff, r1im_ff, r2re_ff, r2im_ff;
   logic signed [MUL_W-1:0]    m1re_ff, m1im_ff, m2re_ff [4:6], m2im_ff [4:6];
   logic signed [46:0]         mx_ff;
   logic signed [STATE_W-1:0]  one_re_ff, one_im_ff, two_re_ff;
   logic signed [49:0]         ow_re_ff, ow_im_ff;

   logic signed [16:0]         d1, d2;
   logic signed [17:0]         w1, w2;
   logic signed [28:0]         x;
   logic signed [STATE_W-1:0]  re1, im1, re2, im2;
   logic signed [STATE_W-1:0]  one_re_in, one_im_in, two_re_in, two_im_in;

   always_comb begin
      d1  = $signed({1'b0, first_decay});
      d2  = $signed({1'b0, second_decay});
      w1  = 18'sd65536 - 18'(d1);
      w2  = 18'sd65536 - 18'(d2);
      x   = {sample, 13'b0};
      re1 = $signed(rd1_ff[2*STATE_W-1:STATE_W]);
      im1 = $signed(rd1_ff[STATE_W-1:0]);
      re2 = $signed(rd2_ff[2*STATE_W-1:STATE_W]);
      im2 = $signed(rd2_ff[STATE_W-1:0]);
      one_re_in = clamp32(MIX_W'(m1re_ff) + MIX_W'(mx_ff));
      one_im_in = clamp32(MIX_W'(m1im_ff));
      two_re_in = clamp32(MIX_W'(m2re_ff[6]) + MIX_W'(ow_re_ff));
      two_im_in = clamp32(MIX_W'(m2im_ff[6]) + MIX_W'(ow_im_ff));
   end

   // Bins are distinct within a request and requests never overlap, so a
   // read never meets a pending write to the same entry.
   always_ff @(posedge clock) begin
      rd1_ff <= mem_one[k_in];
      rd2_ff <= mem_two[k_in];
      if (clr_en) begin
         mem_one[clr_addr] <= '0;
      end else if (tag_ff[4].vld) begin
         mem_one[k_ff[4]] <= {one_re_in, one_im_in};
      end
      if (clr_en) begin
         mem_two[clr_addr] <= '0;
      end else if (tag_ff[6].vld) begin
         mem_two[k_ff[6]] <= {two_re_in, two_im_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= 7; i++) begin
            tag_ff[i] <= '0;
         end
      end else begin
         tag_ff[1] <= tag_in;
         for (int i = 2; i <= 7; i++) begin
            tag_ff[i] <= tag_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff[1] <= k_in;
      for (int i = 2; i <= 6; i++) begin
         k_ff[i] <= k_ff[i-1];
      end
      c_ff  <= cos_in;
      s_ff  <= sin_in;
      pa_ff <= re1 * c_ff;
      pb_ff <= im1 * s_ff;
      pc_ff <= re1 * s_ff;
      pd_ff <= im1 * c_ff;
      pe_ff <= re2 * c_ff;
      pf_ff <= im2 * s_ff;
      pg_ff <= re2 * s_ff;
      ph_ff <= im2 * c_ff;
      r1re_ff <= RES_W'((pa_ff - pb_ff) >>> 24);
      r1im_ff <= RES_W'((pc_ff + pd_ff) >>> 24);
      r2re_ff <= RES_W'((pe_ff - pf_ff) >>> 24);
      r2im_ff <= RES_W'((pg_ff + ph_ff) >>> 24);
      m1re_ff    <= r1re_ff * d1;
      m1im_ff    <= r1im_ff * d1;
      mx_ff      <= x * w1;
      m2re_ff[4] <= r2re_ff * d2;
      m2im_ff[4] <= r2im_ff * d2;
      one_re_ff  <= one_re_in;
      one_im_ff  <= one_im_in;
      for (int i = 5; i <= 6; i++) begin
         m2re_ff[i] <= m2re_ff[i-1];
         m2im_ff[i] <= m2im_ff[i-1];
      end
      ow_re_ff  <= one_re_ff * w2;
      ow_im_ff  <= one_im_ff * w2;
      two_re_ff <= two_re_in;
   end

   assign tag_out    = tag_ff[7];
   assign two_re_out = two_re_ff;

endmodule

`default_nettype wire

FILE: bench/tb.sv
// Self-checking bench for damped_resonator_bank_filter_core: sample requests in, filtered
// samples out, each compared with a resonator bank model held in the bench or with a value pinned in the plan.
// Depends on drbf_pkg and the core RTL.
`default_nettype none

module tb;
   import drbf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [15:0] req_audio_in = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [23:0] rsp_filtered_out;
   logic               csr_we = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [23:0]        csr_wdata = '0;

   damped_resonator_bank_filter_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_audio_in(req_audio_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_filtered_out(rsp_filtered_out),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Bench copy of the register file and of both resonator stages.
   logic [15:0] first_decay_q  = FIRST_DECAY_RST;
   logic [15:0] second_decay_q = SECOND_DECAY_RST;
   logic [23:0] freq_step_q    = FREQ_STEP_RST;
   logic [7:0]  output_gain_q  = OUTPUT_GAIN_RST;
   int one_re[DEF_BINS], one_im[DEF_BINS], two_re[DEF_BINS], two_im[DEF_BINS];

   logic signed [23:0] filtered_due[$];
   int  errors = 0;
   int  rsp_seen = 0;
   bit  calm = 1'b0;
   bit  pinned = 1'b0;
   logic signed [23:0] pinned_value;

   function automatic void rotator(input logic [23:0] angle, output longint c, output longint s);
      logic [23:0] b;
      longint u, u2, ps, pc, sv, cv;
      b  = angle + 24'h200000;
      u  = longint'(b[21:0]) - 64'sd2097152;
      u2 = (u * u) >>> 24;
      ps = ((longint'(C_SIN9) * u2) >>> 24) + longint'(C_SIN7);
      ps = ((ps * u2) >>> 24) + longint'(C_SIN5);
      ps = ((ps * u2) >>> 24) + longint'(C_SIN3);
      ps = ((ps * u2) >>> 24) + longint'(C_SIN1);
      sv = (ps * u) >>> 24;
      pc = ((longint'(C_COS10) * u2) >>> 24) + longint'(C_COS8);
      pc = ((pc * u2) >>> 24) + longint'(C_COS6);
      pc = ((pc * u2) >>> 24) + longint'(C_COS4);
      pc = ((pc * u2) >>> 24) + longint'(C_COS2);
      cv = ((pc * u2) >>> 24) + longint'(C_COS0);
      case (b[23:22])
         2'd0: begin c = cv;  s = sv;  end
         2'd1: begin c = -sv; s = cv;  end
         2'd2: begin c = -cv; s = -sv; end
         default: begin c = sv; s = -cv; end
      endcase
   endfunction

   function automatic int clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
   endfunction

   function automatic void resonate(inout int re, inout int im, input longint c, input longint s,
                                    input longint d, input longint in_re, input longint in_im);
      longint r, i, w;
      r  = (longint'(re) * c - longint'(im) * s) >>> 24;
      i  = (longint'(re) * s + longint'(im) * c) >>> 24;
      w  = 64'sd65536 - d;
      re = clamp32((r * d + in_re * w) >>> 16);
      im = clamp32((i * d + in_im * w) >>> 16);
   endfunction

   // Advances both stages by one sample and returns the filtered output.
   function automatic logic signed [23:0] bank_filter(input logic signed [15:0] smp);
      longint x, sum, res, c, s;
      logic [23:0] angle;
      x = longint'(smp) * 8192;
      sum = 0;
      for (int k = 0; k < DEF_BINS; k++) begin
         angle = 24'(longint'(k) * longint'(freq_step_q));
         rotator(angle, c, s);
         resonate(one_re[k], one_im[k], c, s, longint'(first_decay_q), x, 0);
         resonate(two_re[k], two_im[k], c, s, longint'(second_decay_q),
                  longint'(one_re[k]), longint'(one_im[k]));
         sum += longint'(two_re[k]);
      end
      res = (sum * longint'(output_gain_q)) >>> 13;
      if (res > 64'sd8388607) res = 64'sd8388607;
      if (res < -64'sd8388608) res = -64'sd8388608;
      return 24'(res);
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (pinned) begin
               void'(bank_filter(req_audio_in));
               filtered_due.push_back(pinned_value);
            end else begin
               filtered_due.push_back(bank_filter(req_audio_in));
            end
         end
         if (rsp_valid && rsp_ready) begin
            rsp_seen++;
            if (filtered_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected result %0d", $time, rsp_filtered_out);
            end else if (rsp_filtered_out !== filtered_due[0]) begin
               errors++;
               $display("%0t: filtered_out expected %0d actual %0d", $time,
                        filtered_due[0], rsp_filtered_out);
               void'(filtered_due.pop_front());
            end else begin
               void'(filtered_due.pop_front());
            end
         end
      end
   end

   // Receiver: random back-pressure, plus one long hold-off that fills the block.
   initial begin
      bit held;
      held = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (!held && rsp_seen >= 40) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (5000) @(negedge clock);
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= 12);
         end
      end
   end

   task automatic send_sample(input logic signed [15:0] smp, input bit pin,
                              input logic signed [23:0] value);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_audio_in <= smp;
      pinned       = pin;
      pinned_value = value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Lowers the request and waits until every result is back and the core is at rest.
   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      pinned = 1'b0;
      while (filtered_due.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [23:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         REG_FIRST_DECAY:  first_decay_q  = value[15:0];
         REG_SECOND_DECAY: second_decay_q = value[15:0];
         REG_FREQ_STEP:    freq_step_q    = value;
         REG_OUTPUT_GAIN:  output_gain_q  = value[7:0];
         default: begin
         end
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic signed [15:0] pick_sample();
      int sel;
      sel = $urandom_range(99);
      if (sel < 30) return 16'($urandom);
      if (sel < 55) return 16'($urandom_range(512) - 256);
      if (sel < 65) return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      return 16'($urandom_range(16384) - 8192);
   endfunction

   function automatic logic [15:0] pick_decay();
      case ($urandom_range(4))
         0: return 16'd0;
         1: return 16'd65535;
         2: return 16'($urandom);
         default: return 16'($urandom_range(65535, 60000));
      endcase
   endfunction

   function automatic logic [23:0] pick_step();
      case ($urandom_range(5))
         0: return 24'd0;
         1: return 24'd8388608;
         2: return 24'hFFFFFF;
         3: return 24'($urandom);
         default: return 24'($urandom_range(20000));
      endcase
   endfunction

   function automatic logic [7:0] pick_gain();
      case ($urandom_range(3))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   typedef struct {
      bit                 is_reg;
      logic [1:0]         idx;
      logic [23:0]        value;
      logic signed [15:0] smp;
      bit                 pin;
      logic signed [23:0] result;
   } step_row_type;

   // With both decays at zero every bin copies the sample, so the output is
   // sample * 1024 * gain, saturated.
   step_row_type plan[] = '{
      '{0, REG_FIRST_DECAY, 0, 16'sd0, 1, 24'sd0},
      '{0, REG_FIRST_DECAY, 0, 16'sd0, 1, 24'sd0},
      '{0, REG_FIRST_DECAY, 0, 16'sh7FFF, 0, 0},
      '{0, REG_FIRST_DECAY, 0, 16'sh8000, 0, 0},
      '{0, REG_FIRST_DECAY, 0, 16'sd1, 0, 0},
      '{0, REG_FIRST_DECAY, 0, -16'sd1, 0, 0},
      '{0, REG_FIRST_DECAY, 0, 16'sh5555, 0, 0},
      '{1, REG_FIRST_DECAY, 24'd0, 0, 0, 0},
      '{1, REG_SECOND_DECAY, 24'd0, 0, 0, 0},
      '{1, REG_OUTPUT_GAIN, 24'd1, 0, 0, 0},
      '{0, REG_FIRST_DECAY, 0, 16'sd1, 1, 24'sd1024},
      '{0, REG_FIRST_DECAY, 0, -16'sd1, 1, -24'sd1024},
      '{1, REG_OUTPUT_GAIN, 24'd255, 0, 0, 0},
      '{0, REG_FIRST_DECAY, 0, 16'sh7FFF, 1, 24'sh7FFFFF},
      '{0, REG_FIRST_DECAY, 0, 16'sh8000, 1, 24'sh800000},
      '{0, REG_FIRST_DECAY, 0, 16'sd0, 1, 24'sd0},
      '{1, REG_OUTPUT_GAIN, 24'd0, 0, 0, 0},
      '{0, REG_FIRST_DECAY, 0, 16'sd12345, 1, 24'sd0},
      '{1, REG_FIRST_DECAY, 24'd65535, 0, 0, 0},
      '{1, REG_SECOND_DECAY, 24'd65535, 0, 0, 0},
      '{1, REG_FREQ_STEP, 24'hFFFFFF, 0, 0, 0},
      '{1, REG_OUTPUT_GAIN, 24'd255, 0, 0, 0},
      '{0, REG_FIRST_DECAY, 0, 16'sh7FFF, 0, 0},
      '{0, REG_FIRST_DECAY, 0, 16'sh7FFF, 0, 0},
      '{0, REG_FIRST_DECAY, 0, 16'sh8000, 0, 0},
      '{1, REG_FREQ_STEP, 24'd0, 0, 0, 0},
      '{0, REG_FIRST_DECAY, 0, 16'sh7FFF, 0, 0},
      '{0, REG_FIRST_DECAY, 0, -16'sd300, 0, 0},
      '{1, REG_FREQ_STEP, 24'd8388608, 0, 0, 0},
      '{0, REG_FIRST_DECAY, 0, 16'sh8000, 0, 0},
      '{0, REG_FIRST_DECAY, 0, 16'sd4000, 0, 0}
   };

   initial begin
      bit prev_reg;
      prev_reg = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_reg) begin
            if (!prev_reg) drain();
            write_reg(plan[i].idx, plan[i].value);
         end else begin
            send_sample(plan[i].smp, plan[i].pin, plan[i].result);
         end
         prev_reg = plan[i].is_reg;
      end

      // Random phases; the first has no random idling on either side.
      for (int ph = 0; ph < 10; ph++) begin
         drain();
         calm = (ph == 0);
         write_reg(REG_FIRST_DECAY, 24'(pick_decay()));
         write_reg(REG_SECOND_DECAY, 24'(pick_decay()));
         write_reg(REG_FREQ_STEP, pick_step());
         write_reg(REG_OUTPUT_GAIN, 24'(pick_gain()));
         for (int n = 0; n < 56; n++) send_sample(pick_sample(), 1'b0, 0);
      end
      calm = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;
      while (filtered_due.size() != 0) @(negedge clock);
      repeat (1100) @(negedge clock);
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #30ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire
